@@ sv/obstacle_haptic_vector_unit_assert.svh @@
// assertion helpers shared by the rtl modules
`ifndef OBSTACLE_HAPTIC_VECTOR_UNIT_ASSERT_SVH
`define OBSTACLE_HAPTIC_VECTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define OHV_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("obstacle haptic vector check failed");

// next-cycle implication, sampled on clock, off during reset
`define OHV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("obstacle haptic vector check failed");

`endif

@@ sv/ohv_pkg.sv @@
`timescale 1ns / 1ps

package ohv_pkg;

   localparam int DIST_W        = 16;
   localparam int TOL_W         = 16;
   localparam int OFFSET_W      = 7;
   localparam int REP_W         = 4;
   localparam int ANGLE_W       = 8;
   localparam int STRENGTH_W    = 15;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int STRENGTH_SHIFT = 29;
   localparam int ANG_STEPS      = 8;
   localparam int DIV_STEPS      = 17;
   localparam int ANG_NUM_W      = TOL_W + 9;
   localparam int ANG_DEN_W      = TOL_W + 1;
   localparam int ANG_LEFT_GAIN  = 135;
   localparam int ANG_RIGHT_GAIN = 45;

   localparam logic [STRENGTH_W-1:0] STRENGTH_MAX  = 15'd32767;
   localparam logic [ANGLE_W-1:0]    ANGLE_CENTER  = 8'd90;
   localparam logic [ANGLE_W-1:0]    ANGLE_MAX     = 8'd180;
   localparam logic [TOL_W-1:0]      TOL_RESET     = 16'd1280;
   localparam logic [OFFSET_W-1:0]   OFFSET_RESET  = 7'd40;
   localparam logic [REP_W-1:0]      REPEATS_RESET = 4'd15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHAKE_ENABLE  = 2'd0,
      CSR_TOLERANCE     = 2'd1,
      CSR_SHAKE_OFFSET  = 2'd2,
      CSR_SHAKE_REPEATS = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_LEFT,
      MUL_RIGHT,
      MUL_CROSS
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_SQ_LEFT,
      ST_SQ_RIGHT,
      ST_CROSS,
      ST_DIVIDE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic              operation;
      logic [DIST_W-1:0] distance;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]    angle;
      logic [STRENGTH_W-1:0] strength;
      logic                  shaking;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic        load;
      logic        ang_init;
      logic        ang_step;
      logic        mul_init;
      mul_sel_type mul_sel;
      logic        mul_step;
      logic        save_sl;
      logic        save_sr;
      logic        div_init;
      logic        div_step;
      logic        emit;
      logic        shaking;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic             out_free;
      logic             burst;
      logic [REP_W-1:0] shake_repeats;
   } status_type;

endpackage

@@ sv/obstacle_haptic_vector_unit.sv @@
`timescale 1ns / 1ps

// Haptic feedback vector from a left and a right obstacle distance. Each req beat replaces
// one stored distance (unsigned Q8.8 metres) and yields a feedback angle and strength; when
// the strength saturates and shaking is on, the result is a burst of shaken beats with last
// on the final one. One item at a time: after the accepting cycle the block runs the angle
// divider, the shift-add multiplier (both squares, then their product) and the strength
// divider, then emits one result beat per cycle while rsp is not stalled. req_stall falls
// again as soon as the last result beat sits in the output register.

module obstacle_haptic_vector_unit import ohv_pkg::*; #(
   parameter int DIST_BITS   = 16,
   parameter int MAX_REPEATS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   ohv_ctrl #(
      .DIST_BITS   (DIST_BITS),
      .MAX_REPEATS (MAX_REPEATS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ohv_datapath #(
      .DIST_BITS (DIST_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule

@@ sv/ohv_datapath.sv @@
`timescale 1ns / 1ps
`include "obstacle_haptic_vector_unit_assert.svh"

module ohv_datapath import ohv_pkg::*; #(
   parameter int DIST_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_payload,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rsp_type                rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int MW  = 2 * DIST_BITS;
   localparam int PW  = 2 * MW;
   localparam int CW  = (DIST_BITS > TOL_W) ? DIST_BITS : TOL_W;
   localparam int NW  = MW + 1 + STRENGTH_SHIFT;
   localparam int SW  = PW + DIV_STEPS - 1;
   localparam int DVW = (NW > SW) ? NW : SW;

   logic                  shake_enable_ff, shake_enable_in;
   logic [TOL_W-1:0]      tolerance_ff, tolerance_in;
   logic [OFFSET_W-1:0]   shake_offset_ff, shake_offset_in;
   logic [REP_W-1:0]      shake_repeats_ff, shake_repeats_in;
   logic [DIST_BITS-1:0]  left_ff, left_in;
   logic [DIST_BITS-1:0]  right_ff, right_in;
   logic                  sign_ff, sign_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [ANG_NUM_W-1:0]  ang_rem_ff, ang_rem_in;
   logic [ANG_NUM_W-1:0]  ang_div_ff, ang_div_in;
   logic [ANG_STEPS-1:0]  ang_q_ff, ang_q_in;
   logic                  ang_zero_ff, ang_zero_in;

   logic [PW-1:0]         mcand_ff, mcand_in;
   logic [MW-1:0]         mplier_ff, mplier_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [MW-1:0]         sl_ff, sl_in;
   logic [MW-1:0]         sr_ff, sr_in;

   logic [DVW-1:0]        div_rem_ff, div_rem_in;
   logic [DVW-1:0]        div_dsh_ff, div_dsh_in;
   logic [DIV_STEPS-1:0]  div_q_ff, div_q_in;

   logic [DIST_BITS-1:0]  dist_new;
   logic [CW-1:0]         tol_c, dl_c, dr_c;
   logic [TOL_W-1:0]      tl, tr;
   logic [ANG_NUM_W-1:0]  ang_num;
   logic [ANG_DEN_W-1:0]  ang_den;
   logic [MW:0]           sum_lr;
   logic                  zero_dist;
   logic                  sat;
   logic [STRENGTH_W-1:0] strength_val;
   logic [ANGLE_W-1:0]    base_angle;
   logic signed [ANGLE_W+1:0] shake_sum;
   logic [ANGLE_W-1:0]    shake_angle;

   assign dist_new = DIST_BITS'(req_payload.distance);

   // clipped distances feed the angle
   assign tol_c   = CW'(tolerance_ff);
   assign dl_c    = CW'(left_ff);
   assign dr_c    = CW'(right_ff);
   assign tl      = (dl_c < tol_c) ? dl_c[TOL_W-1:0] : tolerance_ff;
   assign tr      = (dr_c < tol_c) ? dr_c[TOL_W-1:0] : tolerance_ff;
   assign ang_num = ANG_NUM_W'(tl) * ANG_NUM_W'(ANG_LEFT_GAIN)
                  + ANG_NUM_W'(tr) * ANG_NUM_W'(ANG_RIGHT_GAIN);
   assign ang_den = ANG_DEN_W'(tl) + ANG_DEN_W'(tr);

   assign sum_lr  = {1'b0, sl_ff} + {1'b0, sr_ff};

   assign zero_dist    = (left_ff == '0) || (right_ff == '0);
   assign sat          = zero_dist || (div_q_ff >= DIV_STEPS'(STRENGTH_MAX));
   assign strength_val = sat ? STRENGTH_MAX : div_q_ff[STRENGTH_W-1:0];
   assign base_angle   = ang_zero_ff ? ANGLE_CENTER : ang_q_ff;

   always_comb begin
      shake_sum = sign_ff
         ? $signed({2'b00, base_angle}) - $signed({3'b000, shake_offset_ff})
         : $signed({2'b00, base_angle}) + $signed({3'b000, shake_offset_ff});
      if (shake_sum < $signed({(ANGLE_W+2){1'b0}})) begin
         shake_angle = '0;
      end else if (shake_sum > $signed({2'b00, ANGLE_MAX})) begin
         shake_angle = ANGLE_MAX;
      end else begin
         shake_angle = shake_sum[ANGLE_W-1:0];
      end
   end

   always_comb begin
      shake_enable_in  = shake_enable_ff;
      tolerance_in     = tolerance_ff;
      shake_offset_in  = shake_offset_ff;
      shake_repeats_in = shake_repeats_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      sign_in          = sign_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_in           = rsp_ff;
      ang_rem_in       = ang_rem_ff;
      ang_div_in       = ang_div_ff;
      ang_q_in         = ang_q_ff;
      ang_zero_in      = ang_zero_ff;
      mcand_in         = mcand_ff;
      mplier_in        = mplier_ff;
      prod_in          = prod_ff;
      sl_in            = sl_ff;
      sr_in            = sr_ff;
      div_rem_in       = div_rem_ff;
      div_dsh_in       = div_dsh_ff;
      div_q_in         = div_q_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_SHAKE_ENABLE:  shake_enable_in  = csr_data[0];
            CSR_TOLERANCE:     tolerance_in     = csr_data[TOL_W-1:0];
            CSR_SHAKE_OFFSET:  shake_offset_in  = csr_data[OFFSET_W-1:0];
            CSR_SHAKE_REPEATS: shake_repeats_in = csr_data[REP_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         if (req_payload.operation) begin
            right_in = dist_new;
         end else begin
            left_in = dist_new;
         end
      end

      // angle: restoring divide, one quotient bit per step
      if (cmd.ang_init) begin
         ang_rem_in  = ang_num;
         ang_div_in  = ANG_NUM_W'(ang_den) << (ANG_STEPS - 1);
         ang_q_in    = '0;
         ang_zero_in = (ang_den == '0);
      end else if (cmd.ang_step) begin
         if (ang_rem_ff >= ang_div_ff) begin
            ang_rem_in = ang_rem_ff - ang_div_ff;
            ang_q_in   = {ang_q_ff[ANG_STEPS-2:0], 1'b1};
         end else begin
            ang_q_in   = {ang_q_ff[ANG_STEPS-2:0], 1'b0};
         end
         ang_div_in = ang_div_ff >> 1;
      end

      // shift-add multiplier
      if (cmd.save_sl) begin
         sl_in = prod_ff[MW-1:0];
      end
      if (cmd.save_sr) begin
         sr_in = prod_ff[MW-1:0];
      end
      if (cmd.mul_init) begin
         prod_in = '0;
         case (cmd.mul_sel)
            MUL_LEFT: begin
               mcand_in  = PW'(left_ff);
               mplier_in = MW'(left_ff);
            end
            MUL_RIGHT: begin
               mcand_in  = PW'(right_ff);
               mplier_in = MW'(right_ff);
            end
            MUL_CROSS: begin
               mcand_in  = PW'(sl_ff);
               mplier_in = prod_ff[MW-1:0];
            end
            default: begin
               mcand_in  = '0;
               mplier_in = '0;
            end
         endcase
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end

      // strength: 2^29 * (sl + sr) / (sl * sr), a quotient at or above STRENGTH_MAX saturates
      if (cmd.div_init) begin
         div_rem_in = DVW'(sum_lr) << STRENGTH_SHIFT;
         div_dsh_in = DVW'(prod_ff) << (DIV_STEPS - 1);
         div_q_in   = '0;
      end else if (cmd.div_step) begin
         if (div_rem_ff >= div_dsh_ff) begin
            div_rem_in = div_rem_ff - div_dsh_ff;
            div_q_in   = {div_q_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            div_q_in   = {div_q_ff[DIV_STEPS-2:0], 1'b0};
         end
         div_dsh_in = div_dsh_ff >> 1;
      end

      if (cmd.emit) begin
         rsp_in.angle    = cmd.shaking ? shake_angle : base_angle;
         rsp_in.strength = strength_val;
         rsp_in.shaking  = cmd.shaking;
         rsp_in.last     = cmd.last;
         rsp_valid_in    = 1'b1;
         sign_in         = ~sign_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shake_enable_ff  <= 1'b0;
         tolerance_ff     <= TOL_RESET;
         shake_offset_ff  <= OFFSET_RESET;
         shake_repeats_ff <= REPEATS_RESET;
         left_ff          <= '1;
         right_ff         <= '1;
         sign_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         shake_enable_ff  <= shake_enable_in;
         tolerance_ff     <= tolerance_in;
         shake_offset_ff  <= shake_offset_in;
         shake_repeats_ff <= shake_repeats_in;
         left_ff          <= left_in;
         right_ff         <= right_in;
         sign_ff          <= sign_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      ang_rem_ff  <= ang_rem_in;
      ang_div_ff  <= ang_div_in;
      ang_q_ff    <= ang_q_in;
      ang_zero_ff <= ang_zero_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      prod_ff     <= prod_in;
      sl_ff       <= sl_in;
      sr_ff       <= sr_in;
      div_rem_ff  <= div_rem_in;
      div_dsh_ff  <= div_dsh_in;
      div_q_ff    <= div_q_in;
   end

   assign status.out_free      = !rsp_valid_ff || !rsp_stall;
   assign status.burst         = sat && shake_enable_ff;
   assign status.shake_repeats = shake_repeats_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `OHV_ASSERT_NEXT(a_sign_flips_per_beat, cmd.emit, sign_ff != $past(sign_ff))
   `OHV_ASSERT_NEXT(a_rsp_hold_on_stall, rsp_valid_ff && rsp_stall, rsp_valid_ff && (rsp_ff == $past(rsp_ff)))
   `OHV_ASSERT_IMPL(a_angle_in_range, rsp_valid_ff, rsp_ff.angle <= ANGLE_MAX)

endmodule

@@ sv/ohv_ctrl.sv @@
`timescale 1ns / 1ps
`include "obstacle_haptic_vector_unit_assert.svh"

module ohv_ctrl import ohv_pkg::*; #(
   parameter int DIST_BITS   = 16,
   parameter int MAX_REPEATS = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int MW   = 2 * DIST_BITS;
   localparam int SMAX = (MW > DIV_STEPS) ? MW : DIV_STEPS;
   localparam int SCW  = $clog2(SMAX + 1);
   localparam int CNTW = $clog2(MAX_REPEATS + 1);
   localparam int LW   = (CNTW > REP_W) ? CNTW : REP_W;

   localparam logic [SCW-1:0] ANG_TOP = SCW'(ANG_STEPS);
   localparam logic [SCW-1:0] MUL_TOP = SCW'(MW);
   localparam logic [SCW-1:0] DIV_TOP = SCW'(DIV_STEPS);

   ctrl_state_type  state_ff, state_in;
   logic [SCW-1:0]  cnt_ff, cnt_in;
   logic [CNTW-1:0] ecnt_ff, ecnt_in;

   logic [LW-1:0]   rep_ext;
   logic [CNTW-1:0] burst_len;
   logic            last_beat;

   assign rep_ext = LW'(status.shake_repeats);

   always_comb begin
      if (rep_ext == '0) begin
         burst_len = CNTW'(1);
      end else if (rep_ext > LW'(MAX_REPEATS)) begin
         burst_len = CNTW'(MAX_REPEATS);
      end else begin
         burst_len = CNTW'(rep_ext);
      end
   end

   assign last_beat = !status.burst || (ecnt_ff == burst_len - CNTW'(1));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ecnt_in     = ecnt_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_LEFT;
      req_stall   = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = ANG_TOP;
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            if (cnt_ff == ANG_TOP) begin
               cmd.ang_init = 1'b1;
            end else begin
               cmd.ang_step = 1'b1;
            end
            if (cnt_ff == '0) begin
               cnt_in   = MUL_TOP;
               state_in = ST_SQ_LEFT;
            end else begin
               cnt_in   = cnt_ff - SCW'(1);
            end
         end
         ST_SQ_LEFT: begin
            cmd.mul_sel = MUL_LEFT;
            if (cnt_ff == MUL_TOP) begin
               cmd.mul_init = 1'b1;
            end else begin
               cmd.mul_step = 1'b1;
            end
            if (cnt_ff == '0) begin
               cnt_in   = MUL_TOP;
               state_in = ST_SQ_RIGHT;
            end else begin
               cnt_in   = cnt_ff - SCW'(1);
            end
         end
         ST_SQ_RIGHT: begin
            cmd.mul_sel = MUL_RIGHT;
            if (cnt_ff == MUL_TOP) begin
               cmd.mul_init = 1'b1;
               cmd.save_sl  = 1'b1;
            end else begin
               cmd.mul_step = 1'b1;
            end
            if (cnt_ff == '0) begin
               cnt_in   = MUL_TOP;
               state_in = ST_CROSS;
            end else begin
               cnt_in   = cnt_ff - SCW'(1);
            end
         end
         ST_CROSS: begin
            cmd.mul_sel = MUL_CROSS;
            if (cnt_ff == MUL_TOP) begin
               cmd.mul_init = 1'b1;
               cmd.save_sr  = 1'b1;
            end else begin
               cmd.mul_step = 1'b1;
            end
            if (cnt_ff == '0) begin
               cnt_in   = DIV_TOP;
               state_in = ST_DIVIDE;
            end else begin
               cnt_in   = cnt_ff - SCW'(1);
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == DIV_TOP) begin
               cmd.div_init = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
            if (cnt_ff == '0) begin
               ecnt_in  = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in   = cnt_ff - SCW'(1);
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.shaking = status.burst;
               cmd.last    = last_beat;
               if (last_beat) begin
                  ecnt_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  ecnt_in  = ecnt_ff + CNTW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ecnt_ff  <= ecnt_in;
      end
   end

   `OHV_ASSERT_IMPL(a_emit_needs_slot, cmd.emit, status.out_free)
   `OHV_ASSERT_IMPL(a_burst_count_bound, state_ff == ST_EMIT, ecnt_ff < burst_len)
   `OHV_ASSERT_NEXT(a_accept_then_busy, req_valid && !req_stall, req_stall)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import ohv_pkg::*;

   localparam logic SIDE_LEFT   = 1'b0;
   localparam logic SIDE_RIGHT  = 1'b1;
   localparam int   CYCLE_LIMIT = 5000000;
   localparam int   HOLD_CYCLES = 600;
   localparam int   SETTLE      = 20;
   localparam int   REPORT_MAX  = 10;

   class feedback_book;
      logic [DIST_W-1:0]   left_dist;
      logic [DIST_W-1:0]   right_dist;
      bit                  minus_next;
      logic                shake_on;
      logic [TOL_W-1:0]    tol;
      logic [OFFSET_W-1:0] offset;
      logic [REP_W-1:0]    repeats;
      rsp_type             awaited[$];
      int                  failures;

      function new();
         left_dist  = '1;
         right_dist = '1;
         minus_next = 1'b0;
         shake_on   = 1'b0;
         tol        = TOL_RESET;
         offset     = OFFSET_RESET;
         repeats    = REPEATS_RESET;
         failures   = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SHAKE_ENABLE:  shake_on = data[0];
            CSR_TOLERANCE:     tol = data[TOL_W-1:0];
            CSR_SHAKE_OFFSET:  offset = data[OFFSET_W-1:0];
            CSR_SHAKE_REPEATS: repeats = data[REP_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [ANGLE_W-1:0] aim(logic [DIST_W-1:0] dl, logic [DIST_W-1:0] dr);
         longint cl;
         longint cr;
         longint q;
         cl = (dl < tol) ? dl : tol;
         cr = (dr < tol) ? dr : tol;
         if (cl + cr == 0) return ANGLE_CENTER;
         q = (ANG_LEFT_GAIN * cl + ANG_RIGHT_GAIN * cr) / (cl + cr);
         return q[ANGLE_W-1:0];
      endfunction

      function logic [STRENGTH_W-1:0] intensity(logic [DIST_W-1:0] dl,
                                                logic [DIST_W-1:0] dr);
         logic [127:0] sq_l;
         logic [127:0] sq_r;
         logic [127:0] quotient;
         if (dl == '0 || dr == '0) return STRENGTH_MAX;
         sq_l = 128'(dl) * 128'(dl);
         sq_r = 128'(dr) * 128'(dr);
         // floor of the two exact fractions summed
         quotient = ((128'(1) << STRENGTH_SHIFT) * (sq_l + sq_r)) / (sq_l * sq_r);
         if (quotient >= 128'(STRENGTH_MAX)) return STRENGTH_MAX;
         return quotient[STRENGTH_W-1:0];
      endfunction

      function void take_reading(req_type beat);
         logic [ANGLE_W-1:0]    center;
         logic [STRENGTH_W-1:0] level;
         int                    count;
         int                    swung;
         rsp_type               v;
         if (beat.operation == SIDE_RIGHT) right_dist = beat.distance;
         else left_dist = beat.distance;
         center = aim(left_dist, right_dist);
         level  = intensity(left_dist, right_dist);
         if (level == STRENGTH_MAX && shake_on) begin
            count = (repeats == '0) ? 1 : int'(repeats);
            for (int k = 0; k < count; k++) begin
               swung = minus_next ? int'(center) - int'(offset)
                                  : int'(center) + int'(offset);
               if (swung < 0) swung = 0;
               if (swung > int'(ANGLE_MAX)) swung = int'(ANGLE_MAX);
               v.angle    = swung[ANGLE_W-1:0];
               v.strength = STRENGTH_MAX;
               v.shaking  = 1'b1;
               v.last     = (k == count - 1);
               awaited.push_back(v);
               minus_next = ~minus_next;
            end
         end else begin
            v.angle    = center;
            v.strength = level;
            v.shaking  = 1'b0;
            v.last     = 1'b1;
            awaited.push_back(v);
            minus_next = ~minus_next;
         end
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
      endfunction

      function void match_vector(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected beat angle %0d strength %0d shaking %0b last %0b",
                             got.angle, got.strength, got.shaking, got.last));
            return;
         end
         want = awaited.pop_front();
         if (got.angle !== want.angle || got.strength !== want.strength ||
             got.shaking !== want.shaking || got.last !== want.last)
            report($sformatf({"mismatch: expected angle %0d strength %0d shaking %0b ",
                              "last %0b, got angle %0d strength %0d shaking %0b last %0b"},
                             want.angle, want.strength, want.shaking, want.last,
                             got.angle, got.strength, got.shaking, got.last));
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_payload;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   feedback_book book;
   bit           calm;
   int           hold_len;
   int           cycle_count;

   obstacle_haptic_vector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 32) return DIST_W'($urandom_range(1, 190));
      if (r < 40) return '1;
      if (r < 55) return DIST_W'($urandom_range(191, 3000));
      return DIST_W'($urandom());
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) book.write_register(csr_index_type'(csr_index), csr_data);
         if (req_valid && !req_stall) book.take_reading(req_payload);
         if (rsp_valid && !rsp_stall) book.match_vector(rsp_payload);
      end
   end

   // receiver back-pressure
   initial begin
      int stall_len;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_len > 0) begin
            stall_len = hold_len;
            hold_len  = 0;
         end else begin
            stall_len = pick_gap();
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   task automatic send_item(input logic side, input logic [DIST_W-1:0] reading);
      int      gap;
      req_type beat;
      gap = pick_gap();
      beat.operation = side;
      beat.distance  = reading;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
   endtask

   // junk above the enable, offset and repeats register widths checks the truncation
   task automatic apply_settings(input logic en, input logic [TOL_W-1:0] tol,
                                 input logic [OFFSET_W-1:0] off,
                                 input logic [REP_W-1:0] rep);
      write_reg(CSR_SHAKE_ENABLE, {15'($urandom()), en});
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_SHAKE_OFFSET, {9'($urandom()), off});
      write_reg(CSR_SHAKE_REPEATS, {12'($urandom()), rep});
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int n);
      repeat (n) send_item(1'($urandom()), pick_distance());
   endtask

   initial begin
      book        = new();
      calm        = 1'b0;
      hold_len    = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_write   <= 1'b0;
      csr_index   <= CSR_SHAKE_ENABLE;
      csr_data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, shake off
      send_item(SIDE_LEFT, 16'h0000);
      send_item(SIDE_RIGHT, 16'h0000);
      send_item(SIDE_LEFT, 16'hFFFF);
      send_item(SIDE_RIGHT, 16'hFFFF);
      send_item(SIDE_LEFT, 16'h0001);
      send_item(SIDE_RIGHT, 16'h8000);
      send_item(SIDE_LEFT, 16'h7FFF);
      wait_idle();

      // zero tolerance, zero burst length, full offset
      apply_settings(1'b1, 16'd0, 7'd90, 4'd0);
      send_item(SIDE_LEFT, 16'h0000);
      send_item(SIDE_RIGHT, 16'h0005);
      send_item(SIDE_LEFT, 16'h0100);
      wait_idle();

      // widest tolerance, offset beyond the angle range, longest burst
      apply_settings(1'b1, 16'hFFFF, 7'd127, 4'd15);
      send_item(SIDE_LEFT, 16'h0000);
      send_item(SIDE_RIGHT, 16'hFFFF);
      send_item(SIDE_LEFT, 16'hFFFF);
      send_item(SIDE_RIGHT, 16'h0000);
      send_item(SIDE_RIGHT, 16'h0080);
      send_item(SIDE_LEFT, 16'h0080);
      send_item(SIDE_LEFT, 16'h00B5);
      wait_idle();

      apply_settings(1'b1, 16'd1, 7'd0, 4'd1);
      run_random(50);
      wait_idle();

      // long receiver hold-off while the sender keeps offering
      apply_settings(1'b1, 16'hFFFF, 7'd90, 4'd15);
      hold_len = HOLD_CYCLES;
      run_random(50);
      wait_idle();

      calm = 1'b1;
      apply_settings(1'b0, 16'($urandom()), 7'($urandom_range(0, 127)),
                     4'($urandom()));
      run_random(50);
      wait_idle();
      calm = 1'b0;

      apply_settings(1'b1, 16'($urandom_range(1, 4000)), 7'($urandom_range(0, 127)),
                     4'($urandom()));
      run_random(50);
      wait_idle();

      apply_settings(1'b1, TOL_RESET, OFFSET_RESET, 4'($urandom_range(2, 6)));
      run_random(50);
      wait_idle();

      if (book.failures == 0 && book.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
